>>> hdl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared constants, key tables and types for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned CHAR_W = 8;

	// number of keys with a table entry
	localparam int unsigned KEYMAP_ENTRIES = 58;
	localparam int unsigned KEY_IDX_W = $clog2(KEYMAP_ENTRIES);

	localparam logic [CODE_W-1:0] CODE_PREFIX      = 8'hE0;
	localparam logic [CODE_W-1:0] CODE_SHIFT_MAKE  = 8'h2A;
	localparam logic [CODE_W-1:0] CODE_SHIFT_BREAK = 8'hAA;
	localparam logic [CODE_W-1:0] CODE_CTRL_MAKE   = 8'd29;
	localparam logic [CODE_W-1:0] CODE_CTRL_BREAK  = 8'd157;
	localparam logic [CODE_W-1:0] CODE_UP          = 8'h48;
	localparam logic [CODE_W-1:0] CODE_DOWN        = 8'h50;
	localparam logic [CODE_W-1:0] CODE_RIGHT       = 8'h4D;
	localparam logic [CODE_W-1:0] CODE_LEFT        = 8'h4B;

	localparam logic [CHAR_W-1:0] CTRL_THRESHOLD = 8'd64;
	localparam logic [CHAR_W-1:0] CTRL_REDUCTION = 8'd96;

	localparam logic [CHAR_W-1:0] CHAR_ESC     = 8'h1B;
	localparam logic [CHAR_W-1:0] CHAR_BRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_B       = 8'h42;
	localparam logic [CHAR_W-1:0] CHAR_C       = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_D       = 8'h44;

	// result kinds
	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_ONE  = 2'd1;
	localparam logic [1:0] RES_SEQ  = 2'd2;

	// bytes still to send for one result
	localparam int unsigned REM_W = 2;
	localparam logic [REM_W-1:0] REM_EMPTY = 2'd0;
	localparam logic [REM_W-1:0] REM_LAST  = 2'd1;
	localparam logic [REM_W-1:0] REM_MID   = 2'd2;
	localparam logic [REM_W-1:0] REM_FIRST = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] ch;    // single char, or final letter of a sequence
	} sc2a_result_t;

	localparam logic [CHAR_W-1:0] PLAIN_MAP [0:KEYMAP_ENTRIES-1] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h20
	};

	localparam logic [CHAR_W-1:0] SHIFTED_MAP [0:KEYMAP_ENTRIES-1] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
		8'h00, 8'h20
	};

endpackage

`default_nettype wire

>>> hdl/sc2a_decode.sv
// ----------------------------------------------------------------------------
// sc2a_decode
// Modifier and prefix flags plus the per-scancode translation.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sc2a_pkg::CODE_W-1:0] code,
	input  wire logic                      fire,    // code retires this cycle
	output sc2a_pkg::sc2a_result_t         result
);
	import sc2a_pkg::*;

	logic shift_q, ctrl_q, prefix_q;
	logic shift_d, ctrl_d, prefix_d;
	logic [CHAR_W-1:0] key_ch;
	logic [CHAR_W-1:0] arrow_ch;
	logic [KEY_IDX_W-1:0] key_idx;

	assign key_idx = code[KEY_IDX_W-1:0];

	always_comb begin
		key_ch = shift_q ? SHIFTED_MAP[key_idx] : PLAIN_MAP[key_idx];
		if (ctrl_q && key_ch >= CTRL_THRESHOLD) begin
			key_ch = key_ch - CTRL_REDUCTION;
		end
	end

	always_comb begin
		unique case (code)
			CODE_UP:    arrow_ch = CHAR_A;
			CODE_DOWN:  arrow_ch = CHAR_B;
			CODE_RIGHT: arrow_ch = CHAR_C;
			CODE_LEFT:  arrow_ch = CHAR_D;
			default:    arrow_ch = '0;
		endcase
	end

	always_comb begin
		shift_d     = shift_q;
		ctrl_d      = ctrl_q;
		prefix_d    = prefix_q;
		result.kind = RES_NONE;
		result.ch   = key_ch;
		priority if (code == CODE_PREFIX) begin
			prefix_d = 1'b1;
		end else if (code == CODE_SHIFT_MAKE) begin
			shift_d = 1'b1;
		end else if (code == CODE_SHIFT_BREAK) begin
			shift_d = 1'b0;
		end else if (code == CODE_CTRL_MAKE) begin
			ctrl_d = 1'b1;
		end else if (code == CODE_CTRL_BREAK) begin
			ctrl_d = 1'b0;
		end else if (code[CODE_W-1]) begin
			prefix_d = 1'b0;
		end else begin
			prefix_d = 1'b0;
			if (prefix_q && arrow_ch != '0) begin
				result.kind = RES_SEQ;
				result.ch   = arrow_ch;
			end else if (code < CODE_W'(KEYMAP_ENTRIES) && key_ch != '0) begin
				result.kind = RES_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (fire) begin
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/sc2a_emit.sv
// ----------------------------------------------------------------------------
// sc2a_emit
// Result register: sends one byte or the three-byte arrow sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  sc2a_pkg::sc2a_result_t           result,
	input  wire logic                        load,
	output logic                             can_load,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [sc2a_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] char_byte
	output logic                             m_tlast    // last_of_run
);
	import sc2a_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_after;
	logic [CHAR_W-1:0] ch_q;

	assign m_tvalid  = (rem_q != REM_EMPTY);
	assign m_tlast   = (rem_q == REM_LAST);
	assign rem_after = (m_tvalid && m_tready) ? rem_q - REM_LAST : rem_q;
	assign can_load  = (rem_after == REM_EMPTY);

	always_comb begin
		unique case (rem_q)
			REM_FIRST: m_tdata = CHAR_ESC;
			REM_MID:   m_tdata = CHAR_BRACKET;
			default:   m_tdata = ch_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= REM_EMPTY;
		end else if (load && result.kind == RES_SEQ) begin
			rem_q <= REM_FIRST;
		end else if (load && result.kind == RES_ONE) begin
			rem_q <= REM_LAST;
		end else begin
			rem_q <= rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q <= result.ch;
		end
	end

endmodule

`default_nettype wire

>>> hdl/scancode_to_ascii_decoder_core.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_core
// Set-1 PC keyboard scancode to ASCII translator, US layout.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Transfer carries
//  --------+-----+-----------------------------------------------------
//  s_*     | in  | tdata[7:0] scancode (bit 7 = key release)
//  m_*     | out | tdata[7:0] char_byte, tlast = last_of_run
//
//  Flow: a scancode is decoded in the input register and its result is
//  loaded into the output register when the scancode retires. With
//  m_tready high, codes that give no byte or one byte never wait on
//  each other, so one transfer per cycle is sustained; an arrow key holds
//  the output register for ESC, '[' and the letter; the input register waits.
//  Reset (arst_n low, asynchronous) clears the shift, ctrl and E0 flags and
//  both valid flags. A stall on m_tready backs up into s_tready.
//
`default_nettype none

module scancode_to_ascii_decoder_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sc2a_pkg::CODE_W-1:0]   s_tdata,   // [7:0] scancode
	// output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sc2a_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] char_byte
	output logic                               m_tlast    // last_of_run
);
	import sc2a_pkg::*;

	logic                valid_s1;
	logic [CODE_W-1:0]   code_s1;
	sc2a_result_t        result;
	logic                can_load;
	logic                advance;

	// the input register retires when its result (if any) fits the output
	// register; codes that give nothing never wait on the output side
	assign advance  = valid_s1 && (result.kind == RES_NONE || can_load);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			code_s1 <= s_tdata;
		end
	end

	sc2a_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_s1),
		.fire   (advance),
		.result (result)
	);

	sc2a_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.load     (advance && result.kind != RES_NONE),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

>>> bench/scancode_to_ascii_decoder_core_test.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_core_test
// Self-checking bench for the set-1 scancode to ASCII decoder. Scancodes are
// driven on the input stream and a keyboard model in the bench predicts the
// bytes that each one should cause. A checker compares every output transfer
// with the oldest predicted byte. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module scancode_to_ascii_decoder_core_test;

	import sc2a_pkg::*;

	// one predicted output byte
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_of_run;
	} key_byte_t;

	localparam int unsigned US_KEYS = 58;
	localparam logic [7:0] ASCII_ESC     = 8'h1B;
	localparam logic [7:0] ASCII_BRACKET = 8'h5B;
	localparam logic [7:0] CTRL_FLOOR    = 8'd64;
	localparam logic [7:0] CTRL_DROP     = 8'd96;

	// US layout, unshifted and shifted
	localparam logic [7:0] US_PLAIN [0:US_KEYS-1] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h20
	};
	localparam logic [7:0] US_SHIFTED [0:US_KEYS-1] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
		8'h00, 8'h20
	};

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] scancode
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] char_byte
	logic       m_tlast;            // last_of_run

	// keyboard model state
	logic kb_shift = 1'b0;
	logic kb_ctrl  = 1'b0;
	logic kb_e0    = 1'b0;

	key_byte_t pending_chars[$];
	int        fail_count = 0;
	int        rx_stall   = 0;
	// set while a stretch runs with no idling on either side
	logic      pace_off   = 1'b0;

	scancode_to_ascii_decoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Keyboard model: updates the flags and queues the bytes one scancode
	// should produce.
	function automatic void predict_keystroke(input logic [7:0] code);
		logic [7:0] arrow_letter;
		logic [7:0] ch;
		arrow_letter = 8'h00;
		if (code == CODE_PREFIX) begin
			kb_e0 = 1'b1;
			return;
		end
		// modifiers leave the E0 flag alone
		if (code == CODE_SHIFT_MAKE) begin
			kb_shift = 1'b1;
			return;
		end
		if (code == CODE_SHIFT_BREAK) begin
			kb_shift = 1'b0;
			return;
		end
		if (code == CODE_CTRL_MAKE) begin
			kb_ctrl = 1'b1;
			return;
		end
		if (code == CODE_CTRL_BREAK) begin
			kb_ctrl = 1'b0;
			return;
		end
		// any other release drops a pending E0
		if (code[7]) begin
			kb_e0 = 1'b0;
			return;
		end
		if (kb_e0) begin
			kb_e0 = 1'b0;
			case (code)
				CODE_UP:    arrow_letter = 8'h41;
				CODE_DOWN:  arrow_letter = 8'h42;
				CODE_RIGHT: arrow_letter = 8'h43;
				CODE_LEFT:  arrow_letter = 8'h44;
				default:    arrow_letter = 8'h00;
			endcase
			if (arrow_letter != 8'h00) begin
				pending_chars.push_back('{ASCII_ESC, 1'b0});
				pending_chars.push_back('{ASCII_BRACKET, 1'b0});
				pending_chars.push_back('{arrow_letter, 1'b1});
				return;
			end
			// prefixed non-arrow falls through to the tables
		end
		if (code < US_KEYS) begin
			ch = kb_shift ? US_SHIFTED[code] : US_PLAIN[code];
			// ctrl wraps: '[' gives 251, shifted 'A' gives 225
			if (kb_ctrl && ch >= CTRL_FLOOR)
				ch = ch - CTRL_DROP;
			if (ch != 8'h00)
				pending_chars.push_back('{ch, 1'b1});
		end
	endfunction

	// Sends one scancode. Entered and left at a falling edge; valid stays
	// high between back-to-back transfers.
	task automatic send_scancode(input logic [7:0] code);
		int gap;
		gap = pace_off ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = code;
		do @(posedge clk); while (!s_tready);
		predict_keystroke(code);
		@(negedge clk);
	endtask

	// Output checker: one transfer against the oldest predicted byte.
	always @(posedge clk) begin
		key_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected transfer: char_byte %0d last_of_run %0d",
					m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.char_byte) begin
					$error("char_byte: expected %0d, got %0d", want.char_byte, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
						want.last_of_run, m_tlast);
					fail_count++;
				end
			end
			rx_stall = pace_off ? 0 : $urandom_range(0, 7);
		end
	end

	// Receiver back-pressure: ready drops for the drawn number of cycles
	// after each transfer, so stalls land mid-sequence too.
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready = 1'b0;
			rx_stall = rx_stall - 1;
		end else begin
			m_tready = 1'b1;
		end
	end

	// Extremes of the code byte and codes without a table entry.
	task automatic test_plain_keys();
		send_scancode(8'h00);            // table slot with no character
		send_scancode(8'h01);            // ESC key
		send_scancode(8'h39);            // space, last table entry
		send_scancode(8'h3A);            // first code past the table
		send_scancode(8'hFF);            // release with every bit set
	endtask

	// Shift and ctrl, alone and together, with ctrl wrap-around.
	task automatic test_modifiers();
		send_scancode(CODE_SHIFT_MAKE);
		send_scancode(8'h35);            // '?'
		send_scancode(CODE_CTRL_MAKE);
		send_scancode(8'h1E);            // shifted 'A' under ctrl
		send_scancode(CODE_SHIFT_BREAK);
		send_scancode(8'h1A);            // '[' under ctrl
		send_scancode(8'h02);            // '1' stays below the ctrl floor
		send_scancode(CODE_CTRL_BREAK);
	endtask

	// E0 sequences: all four arrows, repeated prefix, modifiers inside the
	// sequence, a release that cancels it, and a prefixed ordinary key.
	task automatic test_arrow_keys();
		send_scancode(CODE_PREFIX);
		send_scancode(CODE_UP);
		send_scancode(CODE_PREFIX);
		send_scancode(CODE_PREFIX);
		send_scancode(CODE_DOWN);
		send_scancode(CODE_PREFIX);
		send_scancode(CODE_SHIFT_MAKE);
		send_scancode(CODE_RIGHT);
		send_scancode(CODE_PREFIX);
		send_scancode(CODE_SHIFT_BREAK);
		send_scancode(CODE_LEFT);
		send_scancode(CODE_PREFIX);
		send_scancode(8'h9E);            // release clears the prefix
		send_scancode(CODE_UP);          // now just an unmapped code
		send_scancode(CODE_PREFIX);
		send_scancode(8'h10);            // 'q' after E0
	endtask

	// Mostly realistic typing with random content, plus raw noise.
	task automatic test_random_typing(input int n_items);
		int         sent;
		int         pick;
		logic [7:0] code;
		sent = 0;
		while (sent < n_items) begin
			if (sent % 50 == 0)
				pace_off = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				code = 8'($urandom_range(0, US_KEYS - 1));
				send_scancode(code);
				sent++;
				if ($urandom_range(0, 1)) begin
					send_scancode(code | 8'h80);
					sent++;
				end
			end else if (pick < 55) begin
				case ($urandom_range(0, 3))
					0:       code = CODE_SHIFT_MAKE;
					1:       code = CODE_SHIFT_BREAK;
					2:       code = CODE_CTRL_MAKE;
					default: code = CODE_CTRL_BREAK;
				endcase
				send_scancode(code);
				sent++;
			end else if (pick < 75) begin
				case ($urandom_range(0, 3))
					0:       code = CODE_UP;
					1:       code = CODE_DOWN;
					2:       code = CODE_RIGHT;
					default: code = CODE_LEFT;
				endcase
				send_scancode(CODE_PREFIX);
				send_scancode(code);
				sent += 2;
			end else if (pick < 85) begin
				send_scancode(CODE_PREFIX);
				send_scancode(8'($urandom_range(0, 255)));
				sent += 2;
			end else begin
				send_scancode(8'($urandom_range(0, 255)));
				sent++;
			end
		end
		pace_off = 1'b0;
	endtask

	// Stop sending and let every predicted byte come out.
	task automatic test_drain();
		s_tvalid = 1'b0;
		while (pending_chars.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_plain_keys();
		test_modifiers();
		test_arrow_keys();
		test_random_typing(390);
		test_drain();
		if (fail_count == 0) begin
			$display("scancode_to_ascii_decoder_core_test: clean");
		end else begin
			$display("scancode_to_ascii_decoder_core_test: errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("scancode_to_ascii_decoder_core_test: errors");
		$finish;
	end

endmodule
